// ===== design/mlf_pkg.sv =====
// Shared types and codes for the MAC learning forwarder.
package mlf_pkg;

    localparam int MAC_W   = 48;
    localparam int PORT_W  = 4;
    localparam int MASK_W  = 16;
    localparam int ETYPE_W = 16;
    localparam int CMD_W   = 2;
    localparam int ACT_W   = 2;

    // Input command codes.
    localparam logic [CMD_W-1:0] CMD_FRAME = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DOWN  = 2'd2;

    // Result action codes.
    localparam logic [ACT_W-1:0] ACT_ECHO    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_UNICAST = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FLOOD   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_EVENT   = 2'd3;

    typedef enum logic [2:0] {
        KIND_NOP,
        KIND_ECHO,
        KIND_FRAME,
        KIND_UP,
        KIND_DOWN
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic              port_ok;
        logic [PORT_W-1:0] port;
        logic [MAC_W-1:0]  src_mac;
        logic [MAC_W-1:0]  dst_mac;
    } cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [MASK_W-1:0] out_mask;
        logic              learned;
        logic              table_full;
    } result_t;

    typedef struct packed {
        logic              valid;
        logic [PORT_W-1:0] port;
        logic [MAC_W-1:0]  mac;
    } entry_t;

endpackage

// ===== design/mlf_fifo.sv =====
// Small register FIFO used for the command queue and the result queue.
module mlf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== design/mlf_front.sv =====
// Front end: holds the echo ethertype register and classifies each request.
module mlf_front #(
    parameter int PORTS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [mlf_pkg::ETYPE_W-1:0]   cfg_wr_data,
    input  logic                          push,
    input  logic                          full,
    input  logic [mlf_pkg::CMD_W-1:0]     cmd,
    input  logic [mlf_pkg::PORT_W-1:0]    src_port,
    input  logic [mlf_pkg::MAC_W-1:0]     src_mac,
    input  logic [mlf_pkg::MAC_W-1:0]     dst_mac,
    input  logic [mlf_pkg::ETYPE_W-1:0]   ethertype,
    output logic                          cmd_push,
    output mlf_pkg::cmd_t                 cmd_word
);

    import mlf_pkg::*;

    logic [ETYPE_W-1:0] echo_ethertype_reg;
    logic               port_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_ethertype_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            echo_ethertype_reg <= cfg_wr_data;
        end
    end

    // A port at or above PORTS is not port_ok and never enters ports_up.
    assign port_ok  = (32'(src_port) < PORTS);
    assign cmd_push = push && !full;

    always_comb
    begin
        cmd_word.port_ok = port_ok;
        cmd_word.port    = src_port;
        cmd_word.src_mac = src_mac;
        cmd_word.dst_mac = dst_mac;
        case (cmd)
            CMD_FRAME: cmd_word.kind = (ethertype == echo_ethertype_reg) ? KIND_ECHO : KIND_FRAME;
            CMD_UP:    cmd_word.kind = port_ok ? KIND_UP : KIND_NOP;
            CMD_DOWN:  cmd_word.kind = port_ok ? KIND_DOWN : KIND_NOP;
            default:   cmd_word.kind = KIND_NOP;
        endcase
    end

endmodule

// ===== design/mlf_back.sv =====
// Back end: MAC table memory, port state and the sequencer that scans the table.
module mlf_back #(
    parameter int MAC_ENTRIES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  mlf_pkg::cmd_t     cmd_in,
    output logic              cmd_pop,
    input  logic              res_full,
    output logic              res_push,
    output mlf_pkg::result_t  res_out,
    output logic              clearing
);

    import mlf_pkg::*;

    localparam int IW = $clog2(MAC_ENTRIES);
    localparam logic [IW-1:0] LAST = IW'(MAC_ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    entry_t mem [MAC_ENTRIES];
    entry_t rd_data_reg;

    state_t             state_reg, state_next;
    cmd_t               cur_reg, cur_next;
    logic [IW-1:0]      addr_reg, addr_next;
    logic               dv_reg, dv_next;
    logic [IW-1:0]      didx_reg, didx_next;
    logic [MASK_W-1:0]  ports_up_reg, ports_up_next;
    logic               src_hit_reg, src_hit_next;
    logic               free_found_reg, free_found_next;
    logic [IW-1:0]      free_idx_reg, free_idx_next;
    logic               dst_hit_reg, dst_hit_next;
    logic [PORT_W-1:0]  dst_port_reg, dst_port_next;

    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    entry_t             mem_wdata;
    logic [MASK_W-1:0]  own_bit;
    logic [MASK_W-1:0]  cmd_bit;
    logic               learn;

    assign clearing = (state_reg == ST_CLEAR);
    assign own_bit  = cur_reg.port_ok ? (MASK_W'(1) << cur_reg.port) : '0;
    assign cmd_bit  = MASK_W'(1) << cmd_in.port;
    assign learn    = !src_hit_reg && free_found_reg;

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        addr_next       = addr_reg;
        dv_next         = 1'b0;
        didx_next       = didx_reg;
        ports_up_next   = ports_up_reg;
        src_hit_next    = src_hit_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        dst_hit_next    = dst_hit_reg;
        dst_port_next   = dst_port_reg;
        mem_we          = 1'b0;
        mem_waddr       = addr_reg;
        mem_wdata       = '0;
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        res_out         = '0;

        // Entry returned by the read issued in the previous cycle.
        if (dv_reg)
        begin
            if (cur_reg.kind == KIND_FRAME)
            begin
                if (rd_data_reg.valid && rd_data_reg.mac == cur_reg.src_mac)
                begin
                    src_hit_next = 1'b1;
                end
                if (!rd_data_reg.valid && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = didx_reg;
                end
                if (rd_data_reg.valid && rd_data_reg.mac == cur_reg.dst_mac)
                begin
                    dst_hit_next  = 1'b1;
                    dst_port_next = rd_data_reg.port;
                end
            end
            else if (rd_data_reg.valid && rd_data_reg.port == cur_reg.port)
            begin
                mem_we          = 1'b1;
                mem_waddr       = didx_reg;
                mem_wdata       = rd_data_reg;
                mem_wdata.valid = 1'b0;
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_reg;
                mem_wdata = '0;
                if (addr_reg == LAST)
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid && !res_full)
                begin
                    cmd_pop         = 1'b1;
                    cur_next        = cmd_in;
                    addr_next       = '0;
                    src_hit_next    = 1'b0;
                    free_found_next = 1'b0;
                    dst_hit_next    = 1'b0;
                    case (cmd_in.kind)
                        KIND_FRAME:
                        begin
                            state_next = ST_SCAN;
                        end
                        KIND_DOWN:
                        begin
                            ports_up_next = ports_up_reg & ~cmd_bit;
                            state_next    = ST_SCAN;
                        end
                        KIND_UP:
                        begin
                            ports_up_next = ports_up_reg | cmd_bit;
                            state_next    = ST_RESULT;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                dv_next   = 1'b1;
                didx_next = addr_reg;
                if (addr_reg == LAST)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                res_push   = 1'b1;
                state_next = ST_IDLE;
                case (cur_reg.kind)
                    KIND_ECHO:
                    begin
                        res_out.action   = ACT_ECHO;
                        res_out.out_mask = MASK_W'(1) << cur_reg.port;
                    end
                    KIND_FRAME:
                    begin
                        res_out.learned    = learn;
                        res_out.table_full = !src_hit_reg && !free_found_reg;
                        if (learn)
                        begin
                            mem_we          = 1'b1;
                            mem_waddr       = free_idx_reg;
                            mem_wdata.valid = 1'b1;
                            mem_wdata.port  = cur_reg.port;
                            mem_wdata.mac   = cur_reg.src_mac;
                        end
                        if (dst_hit_reg)
                        begin
                            res_out.action   = ACT_UNICAST;
                            res_out.out_mask = MASK_W'(1) << dst_port_reg;
                        end
                        else if (learn && cur_reg.dst_mac == cur_reg.src_mac)
                        begin
                            // The destination is the source that was just learned.
                            res_out.action   = ACT_UNICAST;
                            res_out.out_mask = MASK_W'(1) << cur_reg.port;
                        end
                        else
                        begin
                            res_out.action   = ACT_FLOOD;
                            res_out.out_mask = ports_up_reg & ~own_bit;
                        end
                    end
                    default:
                    begin
                        res_out.action = ACT_EVENT;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            addr_reg       <= '0;
            dv_reg         <= 1'b0;
            ports_up_reg   <= '0;
            cur_reg        <= '0;
            didx_reg       <= '0;
            src_hit_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            dst_hit_reg    <= 1'b0;
            dst_port_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            dv_reg         <= dv_next;
            ports_up_reg   <= ports_up_next;
            cur_reg        <= cur_next;
            didx_reg       <= didx_next;
            src_hit_reg    <= src_hit_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            dst_hit_reg    <= dst_hit_next;
            dst_port_reg   <= dst_port_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[addr_reg];
    end

endmodule

// ===== design/mac_learning_forwarder.sv =====
// Top level of the MAC learning forwarder: front end, command queue, back end, result queue.
// A frame header or a port-down event scans the whole table before its result is pushed.
// Echo frames, port-up and unused commands skip the scan and go straight to the result.
// One request is handled at a time; the back end takes the next only when idle and the result queue has room.
// After reset a clearing pass over all MAC_ENTRIES entries runs with full high; config stays writable.
module mac_learning_forwarder #(
    parameter int MAC_ENTRIES = 64,
    parameter int PORTS       = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [mlf_pkg::ETYPE_W-1:0]  cfg_wr_data,
    input  logic                         push,
    output logic                         full,
    input  logic [mlf_pkg::CMD_W-1:0]    cmd,
    input  logic [mlf_pkg::PORT_W-1:0]   src_port,
    input  logic [mlf_pkg::MAC_W-1:0]    src_mac,
    input  logic [mlf_pkg::MAC_W-1:0]    dst_mac,
    input  logic [mlf_pkg::ETYPE_W-1:0]  ethertype,
    output logic                         empty,
    input  logic                         pop,
    output logic [mlf_pkg::ACT_W-1:0]    action,
    output logic [mlf_pkg::MASK_W-1:0]   out_mask,
    output logic                         learned,
    output logic                         table_full
);

    import mlf_pkg::*;

    cmd_t    cmd_word;
    cmd_t    cmd_head;
    result_t res_word;
    result_t res_head;
    logic    cmd_push, cmd_full, cmd_empty, cmd_pop;
    logic    res_push, res_full;
    logic    clearing;

    assign full = cmd_full || clearing;

    mlf_front #(
        .PORTS (PORTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .full        (full),
        .cmd         (cmd),
        .src_port    (src_port),
        .src_mac     (src_mac),
        .dst_mac     (dst_mac),
        .ethertype   (ethertype),
        .cmd_push    (cmd_push),
        .cmd_word    (cmd_word)
    );

    mlf_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (2)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_word),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (cmd_head),
        .empty (cmd_empty)
    );

    mlf_back #(
        .MAC_ENTRIES (MAC_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd_in    (cmd_head),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_out   (res_word),
        .clearing  (clearing)
    );

    mlf_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_word),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_head),
        .empty (empty)
    );

    assign action     = res_head.action;
    assign out_mask   = res_head.out_mask;
    assign learned    = res_head.learned;
    assign table_full = res_head.table_full;

    // No request enters while the table is being cleared.
    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> full)
        else $error("input accepted during table clearing");

    // The back end only finishes a request when the result queue has room.
    a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    a_cmd_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command popped from an empty queue");

    a_learn_xor_full: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(learned && table_full))
        else $error("result both learned and table full");

endmodule
